@@ rtl/fsp_pkg.sv @@
`default_nettype none

package fsp_pkg;

    localparam int LEN_BITS_DEF  = 20;
    localparam int LINE_BITS_DEF = 32;
    localparam int QUEUE_DEPTH   = 2;
    localparam int LINE_NUM_W    = 32;

    localparam logic [7:0] CHAR_GT    = 8'h3E;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_NL    = 8'h0A;

    localparam logic [2:0] KIND_NAME     = 3'd0;
    localparam logic [2:0] KIND_NAME_END = 3'd1;
    localparam logic [2:0] KIND_SEQ      = 3'd2;
    localparam logic [2:0] KIND_ACCEPT   = 3'd3;
    localparam logic [2:0] KIND_ERROR    = 3'd4;

    localparam logic [2:0] ERR_NONE       = 3'd0;
    localparam logic [2:0] ERR_NO_NAME    = 3'd1;
    localparam logic [2:0] ERR_NO_HEADER  = 3'd2;
    localparam logic [2:0] ERR_UNEQUAL    = 3'd3;
    localparam logic [2:0] ERR_INCREASING = 3'd4;
    localparam logic [2:0] ERR_EMPTY      = 3'd5;

    // Classified input item as it travels from front to back
    typedef struct packed {
        logic       is_end;
        logic       is_gt;
        logic       is_space;
        logic       is_nl;
        logic [7:0] text;
    } fsp_item_t;

    typedef struct packed {
        logic [2:0]            kind;
        logic [7:0]            data;
        logic [2:0]            error_code;
        logic [LINE_NUM_W-1:0] line_number;
        logic                  last;
    } fsp_result_t;

endpackage

`default_nettype wire

@@ rtl/fsp_if.sv @@
`default_nettype none

interface fsp_req_if;
    logic       valid;
    logic       ready;
    logic       req_type;
    logic [7:0] text_byte;

    modport source (output valid, output req_type, output text_byte, input ready);
    modport sink   (input valid, input req_type, input text_byte, output ready);
endinterface

interface fsp_rsp_if;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic [7:0]  data;
    logic [2:0]  error_code;
    logic [31:0] line_number;
    logic        last;

    modport source (output valid, output kind, output data, output error_code,
                    output line_number, output last, input ready);
    modport sink   (input valid, input kind, input data, input error_code,
                    input line_number, input last, output ready);
endinterface

`default_nettype wire

@@ rtl/fsp_front.sv @@
`default_nettype none

module fsp_front (
    fsp_req_if.sink          request,
    output logic             push_valid,
    input  logic             push_ready,
    output fsp_pkg::fsp_item_t push_item
);
    import fsp_pkg::*;

    assign push_valid = request.valid;
    assign request.ready = push_ready;

    always_comb
    begin
        push_item.is_end   = request.req_type;
        push_item.is_gt    = (request.text_byte == CHAR_GT);
        push_item.is_space = (request.text_byte == CHAR_SPACE);
        push_item.is_nl    = (request.text_byte == CHAR_NL);
        push_item.text     = request.text_byte;
    end

endmodule

`default_nettype wire

@@ rtl/fsp_queue.sv @@
`default_nettype none

module fsp_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push_valid,
    output logic               push_ready,
    input  fsp_pkg::fsp_item_t push_item,
    output logic               pop_valid,
    input  logic               pop_ready,
    output fsp_pkg::fsp_item_t pop_item
);
    import fsp_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    fsp_item_t           slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]    wr_ptr_reg;
    logic [PTR_W-1:0]    wr_ptr_next;
    logic [PTR_W-1:0]    rd_ptr_reg;
    logic [PTR_W-1:0]    rd_ptr_next;
    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    count_next;
    logic                do_push;
    logic                do_pop;

    assign push_ready = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_item   = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

@@ rtl/fsp_back.sv @@
`default_nettype none

module fsp_back #(
    parameter int LEN_BITS  = fsp_pkg::LEN_BITS_DEF,
    parameter int LINE_BITS = fsp_pkg::LINE_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               pop_valid,
    output logic               pop_ready,
    input  fsp_pkg::fsp_item_t pop_item,
    fsp_rsp_if.source          result
);
    import fsp_pkg::*;

    localparam logic [2:0] MODE_LINE_START  = 3'd0;
    localparam logic [2:0] MODE_NAME_FIRST  = 3'd1;
    localparam logic [2:0] MODE_NAME        = 3'd2;
    localparam logic [2:0] MODE_HEADER_REST = 3'd3;
    localparam logic [2:0] MODE_SEQ         = 3'd4;
    localparam logic [2:0] MODE_ERROR       = 3'd5;

    logic [2:0]           mode_reg;
    logic [2:0]           mode_next;
    logic                 header_seen_reg;
    logic                 header_seen_next;
    logic [LEN_BITS-1:0]  line_len_reg;
    logic [LEN_BITS-1:0]  line_len_next;
    logic [LEN_BITS-1:0]  prev_len_reg;
    logic [LEN_BITS-1:0]  prev_len_next;
    logic                 prev_valid_reg;
    logic                 prev_valid_next;
    logic [LEN_BITS-1:0]  pprev_len_reg;
    logic [LEN_BITS-1:0]  pprev_len_next;
    logic                 pprev_valid_reg;
    logic                 pprev_valid_next;
    logic [LINE_BITS-1:0] line_cnt_reg;
    logic [LINE_BITS-1:0] line_cnt_next;
    logic                 end_phase_reg;
    logic                 end_phase_next;
    logic                 out_valid_reg;
    fsp_result_t          out_reg;
    fsp_result_t          out_next;
    logic                 out_load;
    logic                 out_room;

    logic [LINE_BITS-1:0]  line_cnt_inc;
    logic [LEN_BITS-1:0]   line_len_inc;
    logic [LINE_NUM_W-1:0] line_num_cur;
    logic [LINE_NUM_W-1:0] line_num_inc;

    assign line_cnt_inc = (line_cnt_reg == '1) ? line_cnt_reg
                                               : line_cnt_reg + LINE_BITS'(1);
    assign line_len_inc = (line_len_reg == '1) ? line_len_reg
                                               : line_len_reg + LEN_BITS'(1);

    // Clamp the line counter onto the 32-bit result field
    generate
        if (LINE_BITS > LINE_NUM_W)
        begin : g_line_wide
            assign line_num_cur = (|line_cnt_reg[LINE_BITS-1:LINE_NUM_W]) ? '1
                                  : line_cnt_reg[LINE_NUM_W-1:0];
            assign line_num_inc = (|line_cnt_inc[LINE_BITS-1:LINE_NUM_W]) ? '1
                                  : line_cnt_inc[LINE_NUM_W-1:0];
        end
        else
        begin : g_line_narrow
            assign line_num_cur = LINE_NUM_W'(line_cnt_reg);
            assign line_num_inc = LINE_NUM_W'(line_cnt_inc);
        end
    endgenerate

    assign out_room = !out_valid_reg || result.ready;

    always_comb
    begin
        mode_next        = mode_reg;
        header_seen_next = header_seen_reg;
        line_len_next    = line_len_reg;
        prev_len_next    = prev_len_reg;
        prev_valid_next  = prev_valid_reg;
        pprev_len_next   = pprev_len_reg;
        pprev_valid_next = pprev_valid_reg;
        line_cnt_next    = line_cnt_reg;
        end_phase_next   = end_phase_reg;
        pop_ready        = 1'b0;
        out_load         = 1'b0;
        out_next         = '0;

        if (pop_valid)
        begin
            if (!pop_item.is_end)
            begin
                if (mode_reg == MODE_ERROR)
                begin
                    // drop bytes until the end item
                    pop_ready = 1'b1;
                end
                else if (out_room)
                begin
                    pop_ready     = 1'b1;
                    out_load      = 1'b1;
                    out_next.last = 1'b1;
                    out_next.kind = KIND_ACCEPT;
                    unique case (mode_reg)
                        MODE_LINE_START:
                        begin
                            line_cnt_next = line_cnt_inc;
                            if (pop_item.is_gt)
                            begin
                                header_seen_next = 1'b1;
                                prev_valid_next  = 1'b0;
                                pprev_valid_next = 1'b0;
                                prev_len_next    = '0;
                                pprev_len_next   = '0;
                                mode_next        = MODE_NAME_FIRST;
                            end
                            else if (!header_seen_reg)
                            begin
                                out_next.kind        = KIND_ERROR;
                                out_next.error_code  = ERR_NO_HEADER;
                                out_next.line_number = line_num_inc;
                                mode_next            = MODE_ERROR;
                            end
                            else if (pop_item.is_nl)
                            begin
                                // empty line closes as a line of length zero
                                pprev_len_next   = prev_len_reg;
                                pprev_valid_next = prev_valid_reg;
                                prev_len_next    = '0;
                                prev_valid_next  = 1'b1;
                                line_len_next    = '0;
                            end
                            else if (pprev_valid_reg && (prev_len_reg != pprev_len_reg))
                            begin
                                out_next.kind        = KIND_ERROR;
                                out_next.error_code  = ERR_UNEQUAL;
                                out_next.line_number = line_num_inc;
                                mode_next            = MODE_ERROR;
                            end
                            else if (prev_valid_reg && (prev_len_reg == '0))
                            begin
                                line_len_next        = LEN_BITS'(1);
                                out_next.kind        = KIND_ERROR;
                                out_next.error_code  = ERR_INCREASING;
                                out_next.line_number = line_num_inc;
                                mode_next            = MODE_ERROR;
                            end
                            else
                            begin
                                line_len_next = LEN_BITS'(1);
                                mode_next     = MODE_SEQ;
                                out_next.kind = KIND_SEQ;
                                out_next.data = pop_item.text;
                            end
                        end
                        MODE_NAME_FIRST:
                        begin
                            if (pop_item.is_space || pop_item.is_nl)
                            begin
                                out_next.kind        = KIND_ERROR;
                                out_next.error_code  = ERR_NO_NAME;
                                out_next.line_number = line_num_cur;
                                mode_next            = MODE_ERROR;
                            end
                            else
                            begin
                                mode_next     = MODE_NAME;
                                out_next.kind = KIND_NAME;
                                out_next.data = pop_item.text;
                            end
                        end
                        MODE_NAME:
                        begin
                            if (pop_item.is_nl)
                            begin
                                mode_next     = MODE_LINE_START;
                                out_next.kind = KIND_NAME_END;
                            end
                            else if (pop_item.is_space)
                            begin
                                mode_next = MODE_HEADER_REST;
                            end
                            else
                            begin
                                out_next.kind = KIND_NAME;
                                out_next.data = pop_item.text;
                            end
                        end
                        MODE_HEADER_REST:
                        begin
                            if (pop_item.is_nl)
                            begin
                                mode_next     = MODE_LINE_START;
                                out_next.kind = KIND_NAME_END;
                            end
                        end
                        MODE_SEQ:
                        begin
                            if (pop_item.is_nl)
                            begin
                                pprev_len_next   = prev_len_reg;
                                pprev_valid_next = prev_valid_reg;
                                prev_len_next    = line_len_reg;
                                prev_valid_next  = 1'b1;
                                line_len_next    = '0;
                                mode_next        = MODE_LINE_START;
                            end
                            else
                            begin
                                line_len_next = line_len_inc;
                                if (prev_valid_reg && (line_len_inc > prev_len_reg))
                                begin
                                    out_next.kind        = KIND_ERROR;
                                    out_next.error_code  = ERR_INCREASING;
                                    out_next.line_number = line_num_cur;
                                    mode_next            = MODE_ERROR;
                                end
                                else
                                begin
                                    out_next.kind = KIND_SEQ;
                                    out_next.data = pop_item.text;
                                end
                            end
                        end
                        default:
                        begin
                            out_load = 1'b0;
                        end
                    endcase
                end
            end
            else if (mode_reg == MODE_ERROR)
            begin
                // silent recovery: consume the end item and start over
                pop_ready        = 1'b1;
                mode_next        = MODE_LINE_START;
                header_seen_next = 1'b0;
                line_len_next    = '0;
                prev_len_next    = '0;
                prev_valid_next  = 1'b0;
                pprev_len_next   = '0;
                pprev_valid_next = 1'b0;
                line_cnt_next    = '0;
                end_phase_next   = 1'b0;
            end
            else if (out_room)
            begin
                out_load = 1'b1;
                if (((mode_reg == MODE_NAME) || (mode_reg == MODE_HEADER_REST))
                    && !end_phase_reg)
                begin
                    // close the open header first; the end item stays queued and is taken with the final result
                    out_next.kind  = KIND_NAME_END;
                    end_phase_next = 1'b1;
                end
                else
                begin
                    pop_ready     = 1'b1;
                    out_next.last = 1'b1;
                    if (mode_reg == MODE_NAME_FIRST)
                    begin
                        out_next.kind        = KIND_ERROR;
                        out_next.error_code  = ERR_NO_NAME;
                        out_next.line_number = line_num_cur;
                    end
                    else if (!header_seen_reg)
                    begin
                        out_next.kind       = KIND_ERROR;
                        out_next.error_code = ERR_EMPTY;
                    end
                    else
                    begin
                        out_next.kind = KIND_ACCEPT;
                    end
                    mode_next        = MODE_LINE_START;
                    header_seen_next = 1'b0;
                    line_len_next    = '0;
                    prev_len_next    = '0;
                    prev_valid_next  = 1'b0;
                    pprev_len_next   = '0;
                    pprev_valid_next = 1'b0;
                    line_cnt_next    = '0;
                    end_phase_next   = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg        <= MODE_LINE_START;
            header_seen_reg <= 1'b0;
            line_len_reg    <= '0;
            prev_len_reg    <= '0;
            prev_valid_reg  <= 1'b0;
            pprev_len_reg   <= '0;
            pprev_valid_reg <= 1'b0;
            line_cnt_reg    <= '0;
            end_phase_reg   <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            mode_reg        <= mode_next;
            header_seen_reg <= header_seen_next;
            line_len_reg    <= line_len_next;
            prev_len_reg    <= prev_len_next;
            prev_valid_reg  <= prev_valid_next;
            pprev_len_reg   <= pprev_len_next;
            pprev_valid_reg <= pprev_valid_next;
            line_cnt_reg    <= line_cnt_next;
            end_phase_reg   <= end_phase_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_reg <= out_next;
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.kind        = out_reg.kind;
    assign result.data        = out_reg.data;
    assign result.error_code  = out_reg.error_code;
    assign result.line_number = out_reg.line_number;
    assign result.last        = out_reg.last;

endmodule

`default_nettype wire

@@ rtl/fasta_stream_parser.sv @@
`default_nettype none

// FASTA stream parser. Send one text byte per request item (req_type 0) and
// close the input with an end item (req_type 1). Header names come out byte
// by byte with a name-end mark, sequence bytes come out without newlines, and
// every other byte yields an "accepted" result; the first rule violation yields
// an error with its line number (none for an empty input), after which bytes
// are dropped until the end item. Throughput is one item per cycle while the
// result side does not stall: each byte that is not dropped gives one result and
// the back-end state machine retires one item per clock. An end item that closes
// an open header gives two results. A two-entry queue sits between the byte
// classifier and the state machine, and a single output register holds each
// result, so an accepted byte passes a queue slot and then the output register.
module fasta_stream_parser #(
    parameter int LEN_BITS  = fsp_pkg::LEN_BITS_DEF,
    parameter int LINE_BITS = fsp_pkg::LINE_BITS_DEF
) (
    input  wire        clk,
    input  wire        rst_n,
    fsp_req_if.sink    request,
    fsp_rsp_if.source  result
);
    import fsp_pkg::*;

    logic      push_valid;
    logic      push_ready;
    fsp_item_t push_item;
    logic      pop_valid;
    logic      pop_ready;
    fsp_item_t pop_item;

    fsp_front u_front (
        .request    (request),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item)
    );

    fsp_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item)
    );

    fsp_back #(
        .LEN_BITS  (LEN_BITS),
        .LINE_BITS (LINE_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_item  (pop_item),
        .result    (result)
    );

endmodule

`default_nettype wire

@@ rtl/fsp_checker.sv @@
`default_nettype none

module fsp_checker (
    input wire        clk,
    input wire        rst_n,
    input wire        rsp_valid,
    input wire        rsp_ready,
    input wire [2:0]  rsp_kind,
    input wire [7:0]  rsp_data,
    input wire [2:0]  rsp_error_code,
    input wire [31:0] rsp_line_number,
    input wire        rsp_last
);
    import fsp_pkg::*;

    // a stalled result keeps its payload
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_kind) && $stable(rsp_data)
            && $stable(rsp_error_code) && $stable(rsp_line_number) && $stable(rsp_last))
        else $error("result changed while stalled");

    a_err_code: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> ((rsp_kind == KIND_ERROR) == (rsp_error_code != ERR_NONE)))
        else $error("error code does not match result kind");

    a_no_line: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && ((rsp_kind != KIND_ERROR) || (rsp_error_code == ERR_EMPTY))
            |-> (rsp_line_number == '0))
        else $error("line number given without a located error");

    // name and sequence bytes only come from byte items, which end in one result
    a_byte_last: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && ((rsp_kind == KIND_NAME) || (rsp_kind == KIND_SEQ)) |-> rsp_last)
        else $error("byte result not marked last");

    a_data_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_kind != KIND_NAME) && (rsp_kind != KIND_SEQ) |-> (rsp_data == '0))
        else $error("data set on a result without a byte");

endmodule

bind fasta_stream_parser fsp_checker u_fsp_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .rsp_valid       (result.valid),
    .rsp_ready       (result.ready),
    .rsp_kind        (result.kind),
    .rsp_data        (result.data),
    .rsp_error_code  (result.error_code),
    .rsp_line_number (result.line_number),
    .rsp_last        (result.last)
);

`default_nettype wire
